### hw/rtl/r12bs_pkg.sv
package r12bs_pkg;

	// Default build limits
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int DEF_LINE_ALIGN = 32;

	// Field widths
	localparam int BYTE_W  = 8;
	localparam int PIX_W   = 12;
	localparam int IDX_W   = 22;
	localparam int LEN_W   = 23;
	localparam int LW_W    = 13;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B_LEN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_G1_LEN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_G2_LEN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_R_LEN      = 3'd4;

	localparam logic [LW_W-1:0] LINE_WIDTH_RST = 13'd1920;

	// Byte position inside a 3-byte group
	typedef enum logic [1:0] {
		SLOT_BYTE0,
		SLOT_BYTE1,
		SLOT_BYTE2
	} slot_t;

	typedef struct packed {
		logic [LEN_W-1:0] b_len;
		logic [LEN_W-1:0] g1_len;
		logic [LEN_W-1:0] g2_len;
		logic [LEN_W-1:0] r_len;
	} plen_t;

	typedef struct packed {
		logic [PIX_W-1:0] first_pixel;
		logic [PIX_W-1:0] second_pixel;
		logic             odd_row;
	} pix_t;

endpackage

### hw/rtl/raw12_unpack_bayer_split.sv
// Channel | Handshake            | Payload
// --------+----------------------+-----------------------------------------------
// in      | in_valid / in_ready  | data_byte, frame_start
// out     | out_valid/out_ready  | first_pixel, second_pixel, odd_row,
//         |                      | plane_index, first_written, second_written
// cfg     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// One byte is taken per cycle while in_ready is high. After the edge that takes a
// group's third byte, its result moves through the capture stage, which loads at
// that edge, then the row-base multiply, the index add and the result register,
// where the plane length compares settle; out_ready stalls can hold it in any stage.
// Reset clears position counters and stage valids; config registers return to defaults.
// in_ready drops only when every stage holds a transaction and out_ready is low.
module raw12_unpack_bayer_split
	import r12bs_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int LINE_ALIGN = DEF_LINE_ALIGN
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BYTE_W-1:0]     data_byte,
	input  logic                  frame_start,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      first_pixel,
	output logic [PIX_W-1:0]      second_pixel,
	output logic                  odd_row,
	output logic [IDX_W-1:0]      plane_index,
	output logic                  first_written,
	output logic                  second_written
);

	localparam int HALF_W = $clog2(MAX_WIDTH / 2 + 1);
	localparam int ACT_W  = HALF_W + 2;
	localparam int ROW_W  = $clog2(MAX_HEIGHT);

	// Effective half width and active byte count of a line
	logic [HALF_W-1:0] half;
	logic [ACT_W-1:0]  active;
	plen_t             plens;

	// Completed group headed into the index pipeline
	logic              emit_valid;
	pix_t              emit_pix;
	logic [ROW_W-1:0]  emit_row;
	logic [HALF_W-1:0] emit_col;

	r12bs_cfg #(
		.MAX_WIDTH (MAX_WIDTH),
		.HALF_W    (HALF_W),
		.ACT_W     (ACT_W)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.half      (half),
		.active    (active),
		.plens     (plens)
	);

	// Track group slot, line offset, row and pair column; hold the first two bytes
	r12bs_unpack #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.LINE_ALIGN (LINE_ALIGN),
		.HALF_W     (HALF_W),
		.ACT_W      (ACT_W),
		.ROW_W      (ROW_W)
	) u_unpack (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.active      (active),
		.emit_valid  (emit_valid),
		.emit_pix    (emit_pix),
		.emit_row    (emit_row),
		.emit_col    (emit_col)
	);

	// Compute plane index and written flags; drive the result register
	r12bs_index #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.HALF_W     (HALF_W),
		.ROW_W      (ROW_W)
	) u_index (
		.clk            (clk),
		.arst_n         (arst_n),
		.up_valid       (emit_valid),
		.up_ready       (in_ready),
		.up_pix         (emit_pix),
		.up_row         (emit_row),
		.up_col         (emit_col),
		.half           (half),
		.plens          (plens),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.first_pixel    (first_pixel),
		.second_pixel   (second_pixel),
		.odd_row        (odd_row),
		.plane_index    (plane_index),
		.first_written  (first_written),
		.second_written (second_written)
	);

endmodule

### hw/rtl/r12bs_cfg.sv
module r12bs_cfg
	import r12bs_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int HALF_W    = $clog2(MAX_WIDTH / 2 + 1),
	parameter int ACT_W     = HALF_W + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic [HALF_W-1:0]     half,
	output logic [ACT_W-1:0]      active,
	output plen_t                 plens
);

	logic [LW_W-1:0] line_width_q;
	plen_t           plens_q;
	logic [LW_W-1:0] w_even;
	logic [LW_W-1:0] w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
			plens_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_WIDTH: line_width_q   <= cfg_wdata[LW_W-1:0];
				REG_B_LEN:      plens_q.b_len  <= cfg_wdata[LEN_W-1:0];
				REG_G1_LEN:     plens_q.g1_len <= cfg_wdata[LEN_W-1:0];
				REG_G2_LEN:     plens_q.g2_len <= cfg_wdata[LEN_W-1:0];
				REG_R_LEN:      plens_q.r_len  <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Force even, then clamp to 2..MAX_WIDTH
	always_comb begin
		w_even = line_width_q & ~LW_W'(1);
		if (w_even < LW_W'(2)) begin
			w_eff = LW_W'(2);
		end else if (32'(w_even) > MAX_WIDTH) begin
			w_eff = LW_W'(MAX_WIDTH & ~1);
		end else begin
			w_eff = w_even;
		end
	end

	assign half   = HALF_W'(w_eff >> 1);
	assign active = (ACT_W'(half) << 1) + ACT_W'(half);
	assign plens  = plens_q;

endmodule

### hw/rtl/r12bs_unpack.sv
module r12bs_unpack
	import r12bs_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int LINE_ALIGN = DEF_LINE_ALIGN,
	parameter int HALF_W     = $clog2(MAX_WIDTH / 2 + 1),
	parameter int ACT_W      = HALF_W + 2,
	parameter int ROW_W      = $clog2(MAX_HEIGHT)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              frame_start,
	input  logic [ACT_W-1:0]  active,
	output logic              emit_valid,
	output pix_t              emit_pix,
	output logic [ROW_W-1:0]  emit_row,
	output logic [HALF_W-1:0] emit_col
);

	localparam int STRIDE_MAX = ((MAX_WIDTH / 2 * 3 + LINE_ALIGN - 1) / LINE_ALIGN) * LINE_ALIGN;
	localparam int OFF_W      = $clog2(STRIDE_MAX + 1);
	localparam int SUB_W      = (LINE_ALIGN > 1) ? $clog2(LINE_ALIGN) : 1;
	localparam int CW         = ((OFF_W > ACT_W) ? OFF_W : ACT_W) + 1;

	slot_t             slot_q, cur_slot, slot_nxt;
	logic [OFF_W-1:0]  off_q, cur_off;
	logic [SUB_W-1:0]  sub_q, cur_sub, new_sub;
	logic [ROW_W-1:0]  row_q, cur_row;
	logic [HALF_W-1:0] col_q, cur_col;
	logic [BYTE_W-1:0] hold0_q, hold1_q;
	logic [CW-1:0]     floor_next;
	logic              line_end;
	logic              emit;
	logic              take;

	assign take = in_valid && in_ready;

	// Frame start clears the position before the byte is used
	always_comb begin
		cur_slot = frame_start ? SLOT_BYTE0 : slot_q;
		cur_off  = frame_start ? '0 : off_q;
		cur_sub  = frame_start ? '0 : sub_q;
		cur_row  = frame_start ? '0 : row_q;
		cur_col  = frame_start ? '0 : col_q;
	end

	// Next slot, alignment phase and end of line
	always_comb begin
		case (cur_slot)
			SLOT_BYTE0: slot_nxt = SLOT_BYTE1;
			SLOT_BYTE1: slot_nxt = SLOT_BYTE2;
			default:    slot_nxt = SLOT_BYTE0;
		endcase
		new_sub    = (cur_sub == SUB_W'(LINE_ALIGN - 1)) ? '0 : SUB_W'(cur_sub + 1'b1);
		// Next offset rounded down to the alignment; the line ends once that reaches active
		floor_next = CW'(cur_off) + CW'(1) - CW'(new_sub);
		line_end   = floor_next >= CW'(active);
	end

	// Result for a complete group inside the active bytes
	always_comb begin
		emit                  = (cur_slot == SLOT_BYTE2) && (CW'(cur_off) < CW'(active));
		emit_valid            = in_valid && emit;
		emit_pix.first_pixel  = {hold0_q, data_byte[3:0]};
		emit_pix.second_pixel = {hold1_q, data_byte[7:4]};
		emit_pix.odd_row      = cur_row[0];
		emit_row              = cur_row;
		emit_col              = cur_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SLOT_BYTE0;
			off_q  <= '0;
			sub_q  <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (take) begin
			if (line_end) begin
				slot_q <= SLOT_BYTE0;
				off_q  <= '0;
				sub_q  <= '0;
				col_q  <= '0;
				if (cur_row < ROW_W'(MAX_HEIGHT - 1)) begin
					row_q <= ROW_W'(cur_row + 1'b1);
				end else begin
					row_q <= cur_row;
				end
			end else begin
				slot_q <= slot_nxt;
				off_q  <= OFF_W'(cur_off + 1'b1);
				sub_q  <= new_sub;
				row_q  <= cur_row;
				col_q  <= emit ? HALF_W'(cur_col + 1'b1) : cur_col;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && cur_slot == SLOT_BYTE0) begin
			hold0_q <= data_byte;
		end
		if (take && cur_slot == SLOT_BYTE1) begin
			hold1_q <= data_byte;
		end
	end

endmodule

### hw/rtl/r12bs_index.sv
module r12bs_index
	import r12bs_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int HALF_W     = $clog2(MAX_WIDTH / 2 + 1),
	parameter int ROW_W      = $clog2(MAX_HEIGHT)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  pix_t              up_pix,
	input  logic [ROW_W-1:0]  up_row,
	input  logic [HALF_W-1:0] up_col,
	input  logic [HALF_W-1:0] half,
	input  plen_t             plens,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PIX_W-1:0]  first_pixel,
	output logic [PIX_W-1:0]  second_pixel,
	output logic              odd_row,
	output logic [IDX_W-1:0]  plane_index,
	output logic              first_written,
	output logic              second_written
);

	localparam int PROD_W = ROW_W + HALF_W;

	logic              valid_s1, valid_s2, valid_s3, res_valid_q;
	logic              rdy_s1, rdy_s2, rdy_s3, rdy_res;
	pix_t              pix_s1, pix_s2, pix_s3, res_pix_q;
	logic [ROW_W-1:0]  row_s1;
	logic [HALF_W-1:0] col_s1, col_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [IDX_W-1:0]  idx_s3, res_idx_q;
	logic              res_w1_q, res_w2_q;
	logic [LEN_W-1:0]  len1, len2;

	assign rdy_res  = !res_valid_q || out_ready;
	assign rdy_s3   = !valid_s3 || rdy_res;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  valid_s1    <= up_valid;
			if (rdy_s2)  valid_s2    <= valid_s1;
			if (rdy_s3)  valid_s3    <= valid_s2;
			if (rdy_res) res_valid_q <= valid_s3;
		end
	end

	assign len1 = pix_s3.odd_row ? plens.r_len  : plens.g1_len;
	assign len2 = pix_s3.odd_row ? plens.g2_len : plens.b_len;

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			pix_s1 <= up_pix;
			row_s1 <= up_row;
			col_s1 <= up_col;
		end
		// Row base of the quarter plane
		if (rdy_s2 && valid_s1) begin
			pix_s2  <= pix_s1;
			col_s2  <= col_s1;
			prod_s2 <= PROD_W'(row_s1 >> 1) * PROD_W'(half);
		end
		if (rdy_s3 && valid_s2) begin
			pix_s3 <= pix_s2;
			idx_s3 <= IDX_W'(prod_s2) + IDX_W'(col_s2);
		end
		if (rdy_res && valid_s3) begin
			res_pix_q <= pix_s3;
			res_idx_q <= idx_s3;
			res_w1_q  <= LEN_W'(idx_s3) < len1;
			res_w2_q  <= LEN_W'(idx_s3) < len2;
		end
	end

	assign out_valid      = res_valid_q;
	assign first_pixel    = res_pix_q.first_pixel;
	assign second_pixel   = res_pix_q.second_pixel;
	assign odd_row        = res_pix_q.odd_row;
	assign plane_index    = res_idx_q;
	assign first_written  = res_w1_q;
	assign second_written = res_w2_q;

endmodule
